>>> rtl/core/hrlp_pkg.sv
// Shared types, constants and byte classes for the HTTP request line parser.
`timescale 1ns / 1ps

package hrlp_pkg;

  // Counter width default and fixed width of the reported lengths.
  localparam int LEN_BITS_DEF = 12;
  localparam int OUT_LEN_W    = 12;
  localparam int OUT_LEN_MAX  = (1 << OUT_LEN_W) - 1;

  // Request line phases.
  localparam logic [3:0] PH_METHOD_FIRST = 4'd0;
  localparam logic [3:0] PH_METHOD       = 4'd1;
  localparam logic [3:0] PH_SPACE1       = 4'd2;
  localparam logic [3:0] PH_TARGET       = 4'd3;
  localparam logic [3:0] PH_SPACE2       = 4'd4;
  localparam logic [3:0] PH_VERSION      = 4'd5;
  localparam logic [3:0] PH_CR           = 4'd6;
  localparam logic [3:0] PH_LINE_OK      = 4'd7;
  localparam logic [3:0] PH_FAIL         = 4'd8;

  // Header end detection phases.
  localparam logic [1:0] END_IDLE = 2'd0;
  localparam logic [1:0] END_LF   = 2'd1;
  localparam logic [1:0] END_LFCR = 2'd2;

  // Field tags.
  localparam logic [1:0] TAG_OTHER   = 2'd0;
  localparam logic [1:0] TAG_METHOD  = 2'd1;
  localparam logic [1:0] TAG_TARGET  = 2'd2;
  localparam logic [1:0] TAG_VERSION = 2'd3;

  // Characters.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef struct packed {
    logic [1:0] end_phase;
    logic [3:0] line_phase;
  } hrlp_ctl_t;

  typedef struct packed {
    logic [1:0] tag;
    logic       hdr_end;
    logic       req_ok;
  } hrlp_res_t;

  // RFC token characters.
  function automatic logic tok_ok(input logic [7:0] b);
    logic r;
    begin
      case (b)
        8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
        8'h2D, CH_DOT, 8'h5E, 8'h5F, 8'h60, 8'h7C, CH_TILDE: r = 1'b1;
        default: r = 1'b0;
      endcase
      if (b >= 8'h30 && b <= 8'h39) r = 1'b1;
      if (b >= 8'h61 && b <= 8'h7A) r = 1'b1;
      if (b >= 8'h41 && b <= 8'h5A) r = 1'b1;
      return r;
    end
  endfunction

  // Target bytes: any byte above space (control bytes below it, space and tab are refused).
  function automatic logic tgt_ok(input logic [7:0] b);
    return b > CH_SP;
  endfunction

  function automatic logic ver_ok(input logic [7:0] b);
    return tok_ok(b) || b == CH_SLASH || b == CH_DOT;
  endfunction

endpackage

>>> rtl/core/hrlp_step.sv
// Per-byte next-state and result logic of the request line parser.
`timescale 1ns / 1ps

module hrlp_step #(
  parameter int LEN_BITS = hrlp_pkg::LEN_BITS_DEF
) (
  input  logic [7:0]                       byte_in,
  input  hrlp_pkg::hrlp_ctl_t              ctl,
  input  logic [LEN_BITS-1:0]              method_count,
  input  logic [LEN_BITS-1:0]              target_count,
  input  logic [LEN_BITS-1:0]              version_count,
  output hrlp_pkg::hrlp_ctl_t              ctl_next,
  output logic [LEN_BITS-1:0]              method_count_next,
  output logic [LEN_BITS-1:0]              target_count_next,
  output logic [LEN_BITS-1:0]              version_count_next,
  output hrlp_pkg::hrlp_res_t              res,
  output logic [hrlp_pkg::OUT_LEN_W-1:0]   method_len,
  output logic [hrlp_pkg::OUT_LEN_W-1:0]   target_len,
  output logic [hrlp_pkg::OUT_LEN_W-1:0]   version_len
);
  import hrlp_pkg::*;

  localparam int CW = (LEN_BITS > OUT_LEN_W) ? LEN_BITS : OUT_LEN_W;
  localparam logic [LEN_BITS-1:0] CNT_MAX = {LEN_BITS{1'b1}};

  logic [3:0]          phase;
  logic [1:0]          tag;
  logic [1:0]          end_phase;
  logic                hdr_end;
  logic [LEN_BITS-1:0] m_cnt, t_cnt, v_cnt;

  function automatic logic [OUT_LEN_W-1:0] clip(input logic [LEN_BITS-1:0] c);
    logic [CW-1:0] w;
    begin
      w = CW'(c);
      return (w > CW'(OUT_LEN_MAX)) ? OUT_LEN_W'(OUT_LEN_MAX) : w[OUT_LEN_W-1:0];
    end
  endfunction

  always_comb begin
    phase = PH_FAIL;
    tag   = TAG_OTHER;
    case (ctl.line_phase)
      PH_METHOD_FIRST: begin
        if (tok_ok(byte_in)) begin
          phase = PH_METHOD;
          tag   = TAG_METHOD;
        end
      end
      PH_METHOD: begin
        if (tok_ok(byte_in)) begin
          phase = PH_METHOD;
          tag   = TAG_METHOD;
        end else if (byte_in == CH_SP) begin
          phase = PH_SPACE1;
        end
      end
      PH_SPACE1: begin
        if (byte_in == CH_SP) begin
          phase = PH_SPACE1;
        end else if (tgt_ok(byte_in)) begin
          phase = PH_TARGET;
          tag   = TAG_TARGET;
        end
      end
      PH_TARGET: begin
        if (tgt_ok(byte_in)) begin
          phase = PH_TARGET;
          tag   = TAG_TARGET;
        end else if (byte_in == CH_SP) begin
          phase = PH_SPACE2;
        end else if (byte_in == CH_CR) begin
          phase = PH_CR;
        end
      end
      PH_SPACE2: begin
        if (byte_in == CH_SP) begin
          phase = PH_SPACE2;
        end else if (ver_ok(byte_in)) begin
          phase = PH_VERSION;
          tag   = TAG_VERSION;
        end else if (byte_in == CH_CR) begin
          phase = PH_CR;
        end
      end
      PH_VERSION: begin
        if (ver_ok(byte_in)) begin
          phase = PH_VERSION;
          tag   = TAG_VERSION;
        end else if (byte_in == CH_CR) begin
          phase = PH_CR;
        end
      end
      PH_CR: begin
        if (byte_in == CH_LF) phase = PH_LINE_OK;
      end
      PH_LINE_OK: phase = PH_LINE_OK;
      default:    phase = PH_FAIL;
    endcase
  end

  always_comb begin
    m_cnt = method_count;
    t_cnt = target_count;
    v_cnt = version_count;
    case (tag)
      TAG_METHOD:  if (method_count != CNT_MAX) m_cnt = method_count + 1'b1;
      TAG_TARGET:  if (target_count != CNT_MAX) t_cnt = target_count + 1'b1;
      TAG_VERSION: if (version_count != CNT_MAX) v_cnt = version_count + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    hdr_end   = 1'b0;
    end_phase = END_IDLE;
    if (byte_in == CH_LF) begin
      if (ctl.end_phase == END_LF || ctl.end_phase == END_LFCR) begin
        hdr_end   = 1'b1;
        end_phase = ctl.end_phase;
      end else begin
        end_phase = END_LF;
      end
    end else if (byte_in == CH_CR && ctl.end_phase == END_LF) begin
      end_phase = END_LFCR;
    end
  end

  assign res.tag     = tag;
  assign res.hdr_end = hdr_end;
  assign res.req_ok  = hdr_end && (phase == PH_LINE_OK);

  assign method_len  = clip(m_cnt);
  assign target_len  = clip(t_cnt);
  assign version_len = clip(v_cnt);

  // The header end returns everything to its reset values for the next request.
  always_comb begin
    if (hdr_end) begin
      ctl_next.end_phase  = END_IDLE;
      ctl_next.line_phase = PH_METHOD_FIRST;
      method_count_next   = '0;
      target_count_next   = '0;
      version_count_next  = '0;
    end else begin
      ctl_next.end_phase  = end_phase;
      ctl_next.line_phase = phase;
      method_count_next   = m_cnt;
      target_count_next   = t_cnt;
      version_count_next  = v_cnt;
    end
  end

endmodule

>>> rtl/core/http_request_line_parser_top.sv
// Top level of the HTTP request line parser: input register, state and result register.
//
//   Channel  Direction  Signals                       Contents
//   s_*      in         tvalid tready tdata[7:0]      one request byte per word
//   m_*      out        tvalid tready tdata tlast     tagged byte, header end, ok, lengths
//                       tuser[1:0]
//
// One byte is taken every clock while the output is not stalled; a byte passes the input
// register, then the parser state update, then the result register. Reset (rst,
// synchronous) clears the valid flags and the parser state. A stalled m_tready holds the
// result register and backs up through the input register to s_tready.
`timescale 1ns / 1ps

module http_request_line_parser_top #(
  parameter int LEN_BITS = hrlp_pkg::LEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] data_out, [8] request_ok, [20:9] method_len,
                                 // [32:21] target_len, [44:33] version_len, rest zero
  output logic        m_tlast,   // header_end
  output logic [1:0]  m_tuser    // field_tag
);
  import hrlp_pkg::*;

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 adv;

  hrlp_ctl_t            ctl, ctl_next;
  logic [LEN_BITS-1:0]  method_count, target_count, version_count;
  logic [LEN_BITS-1:0]  method_count_next, target_count_next, version_count_next;
  hrlp_res_t            res;
  logic [OUT_LEN_W-1:0] method_len, target_len, version_len;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_byte <= s_tdata;
  end

  hrlp_step #(.LEN_BITS(LEN_BITS)) u_step (
    .byte_in            (in_byte),
    .ctl                (ctl),
    .method_count       (method_count),
    .target_count       (target_count),
    .version_count      (version_count),
    .ctl_next           (ctl_next),
    .method_count_next  (method_count_next),
    .target_count_next  (target_count_next),
    .version_count_next (version_count_next),
    .res                (res),
    .method_len         (method_len),
    .target_len         (target_len),
    .version_len        (version_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.end_phase  <= END_IDLE;
      ctl.line_phase <= PH_METHOD_FIRST;
      method_count   <= '0;
      target_count   <= '0;
      version_count  <= '0;
    end else if (adv) begin
      ctl           <= ctl_next;
      method_count  <= method_count_next;
      target_count  <= target_count_next;
      version_count <= version_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {3'b000, version_len, target_len, method_len, res.req_ok, in_byte};
      m_tlast <= res.hdr_end;
      m_tuser <= res.tag;
    end
  end

  // A well-formed report only ever comes with the header end.
  a_ok_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> m_tlast)
    else $error("request_ok set on a word that does not end the header");

  // After the header end passes the parser, the state is back at its start.
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (adv && res.hdr_end) |=> (ctl.line_phase == PH_METHOD_FIRST &&
                              ctl.end_phase == END_IDLE && method_count == '0 &&
                              target_count == '0 && version_count == '0))
    else $error("parser state not cleared after header end");

  // A tagged byte leaves the line phase inside the field it was tagged with.
  a_tag_phase: assert property (@(posedge clk) disable iff (rst)
    (adv && res.tag != TAG_OTHER) |=>
      (ctl.line_phase == PH_METHOD || ctl.line_phase == PH_TARGET ||
       ctl.line_phase == PH_VERSION))
    else $error("tagged byte without a matching field phase");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the HTTP request line parser: directed table, then random requests.
`timescale 1ns / 1ps

module tb_top;
  import hrlp_pkg::*;

  localparam int CNT_W     = LEN_BITS_DEF;
  localparam int CNT_LIMIT = (1 << CNT_W) - 1;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_LEN   = 300;
  localparam int RAND_WORDS = 1900;

  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  tag;
    logic        hdr_end;
    logic        ok;
    logic [11:0] mlen;
    logic [11:0] tlen;
    logic [11:0] vlen;
  } parse_res_t;

  typedef struct {
    logic [7:0]  b;
    bit          fixed;
    logic [1:0]  tag;
    logic        hend;
    logic        ok;
    logic [11:0] m;
    logic [11:0] t;
    logic [11:0] v;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  // Typed expectation that travels alongside the byte being offered.
  bit          note_fixed;
  parse_res_t  note_res;

  // Predictor state.
  logic [1:0]       lf_state;
  logic [3:0]       ln_phase;
  logic [CNT_W-1:0] cnt_method;
  logic [CNT_W-1:0] cnt_target;
  logic [CNT_W-1:0] cnt_version;

  bit tok_map [256];
  bit ver_map [256];
  string tok_chars = "!#$%&'*+-.^_`|~0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  string ver_chars;

  parse_res_t expected_q [$];
  int words_in;
  int words_checked;
  int errors;
  int hdr_ends;
  int hdr_oks;
  int requests;
  int idle_cycles;
  int hold_left;
  int rx_wait;
  bit burst;

  dir_row_t dir_rows [27] = '{
    '{"G",       1'b1, TAG_METHOD, 1'b0, 1'b0, 12'd1, 12'd0, 12'd0},
    '{CH_SP,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_SLASH,  1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{8'hFF,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_SP,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{"H",       1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_SLASH,  1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{"1",       1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_CR,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_LF,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_LF,     1'b1, TAG_OTHER,  1'b1, 1'b1, 12'd1, 12'd2, 12'd3},
    '{8'h00,     1'b1, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_LF,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_CR,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{"x",       1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_LF,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_CR,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_LF,     1'b1, TAG_OTHER,  1'b1, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_TILDE,  1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_SP,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_SP,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{"a",       1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_CR,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_LF,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{"Z",       1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_LF,     1'b0, TAG_OTHER,  1'b0, 1'b0, 12'd0, 12'd0, 12'd0},
    '{CH_LF,     1'b1, TAG_OTHER,  1'b1, 1'b1, 12'd1, 12'd1, 12'd0}
  };

  http_request_line_parser_top #(
    .LEN_BITS(CNT_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [11:0] clip_len(input logic [CNT_W-1:0] c);
    return (int'(c) > OUT_LEN_MAX) ? 12'(OUT_LEN_MAX) : 12'(c);
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (int'(c) < CNT_LIMIT) ? c + 1'b1 : c;
  endfunction

  function automatic void clear_parse_state();
    lf_state    = END_IDLE;
    ln_phase    = PH_METHOD_FIRST;
    cnt_method  = '0;
    cnt_target  = '0;
    cnt_version = '0;
  endfunction

  // Advances the predicted line grammar and header end scan by one byte.
  function automatic parse_res_t parse_step(input logic [7:0] b);
    parse_res_t r;
    logic [3:0] nxt;
    logic [1:0] tg;
    logic       done;
    tg   = TAG_OTHER;
    nxt  = PH_FAIL;
    done = 1'b0;
    case (ln_phase)
      PH_METHOD_FIRST: begin
        if (tok_map[b]) begin nxt = PH_METHOD; tg = TAG_METHOD; end
      end
      PH_METHOD: begin
        if (tok_map[b]) begin nxt = PH_METHOD; tg = TAG_METHOD; end
        else if (b == CH_SP) nxt = PH_SPACE1;
      end
      PH_SPACE1: begin
        if (b == CH_SP) nxt = PH_SPACE1;
        else if (b > CH_SP) begin nxt = PH_TARGET; tg = TAG_TARGET; end
      end
      PH_TARGET: begin
        if (b > CH_SP) begin nxt = PH_TARGET; tg = TAG_TARGET; end
        else if (b == CH_SP) nxt = PH_SPACE2;
        else if (b == CH_CR) nxt = PH_CR;
      end
      PH_SPACE2: begin
        if (b == CH_SP) nxt = PH_SPACE2;
        else if (ver_map[b]) begin nxt = PH_VERSION; tg = TAG_VERSION; end
        else if (b == CH_CR) nxt = PH_CR;
      end
      PH_VERSION: begin
        if (ver_map[b]) begin nxt = PH_VERSION; tg = TAG_VERSION; end
        else if (b == CH_CR) nxt = PH_CR;
      end
      PH_CR: begin
        if (b == CH_LF) nxt = PH_LINE_OK;
      end
      PH_LINE_OK: nxt = PH_LINE_OK;
      default: nxt = PH_FAIL;
    endcase
    ln_phase = nxt;
    if (tg == TAG_METHOD) cnt_method = bump(cnt_method);
    else if (tg == TAG_TARGET) cnt_target = bump(cnt_target);
    else if (tg == TAG_VERSION) cnt_version = bump(cnt_version);

    if (b == CH_LF) begin
      if (lf_state == END_LF || lf_state == END_LFCR) done = 1'b1;
      else lf_state = END_LF;
    end else if (b == CH_CR && lf_state == END_LF) begin
      lf_state = END_LFCR;
    end else begin
      lf_state = END_IDLE;
    end

    r.data    = b;
    r.tag     = tg;
    r.hdr_end = done;
    r.ok      = done && (ln_phase == PH_LINE_OK);
    r.mlen    = clip_len(cnt_method);
    r.tlen    = clip_len(cnt_target);
    r.vlen    = clip_len(cnt_version);
    if (done) clear_parse_state();
    return r;
  endfunction

  task automatic report_bad(input string what, input parse_res_t w, input parse_res_t g);
    errors++;
    if (errors <= 10) begin
      $display("%s at %0t: exp data=%02h tag=%0d end=%0b ok=%0b len=%0d/%0d/%0d", what, $realtime,
               w.data, w.tag, w.hdr_end, w.ok, w.mlen, w.tlen, w.vlen);
      $display("    got data=%02h tag=%0d end=%0b ok=%0b len=%0d/%0d/%0d",
               g.data, g.tag, g.hdr_end, g.ok, g.mlen, g.tlen, g.vlen);
    end
  endtask

  // Predicts on each accepted byte and checks each delivered word in order.
  always @(posedge clk) begin : scoreboard
    parse_res_t want;
    parse_res_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = parse_step(s_tdata);
        if (note_fixed) want = note_res;
        expected_q.push_back(want);
        words_in++;
      end
      if (m_tvalid && m_tready) begin
        got.data    = m_tdata[7:0];
        got.tag     = m_tuser;
        got.hdr_end = m_tlast;
        got.ok      = m_tdata[8];
        got.mlen    = m_tdata[20:9];
        got.tlen    = m_tdata[32:21];
        got.vlen    = m_tdata[44:33];
        if (expected_q.size() == 0) begin
          report_bad("unexpected word", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) report_bad("mismatch", want, got);
          words_checked++;
          if (got.hdr_end) hdr_ends++;
          if (got.hdr_end && got.ok) hdr_oks++;
        end
      end
    end
  end

  // Output side pacing: a random stall per word plus a single long hold.
  always @(posedge clk) begin : rx_pace
    int w;
    if (!rst) begin
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (m_tready) begin
        if (m_tvalid) begin
          w = burst ? 0 : $urandom_range(0, 10);
          if (w > 0) begin
            m_tready <= 1'b0;
            rx_wait = w - 1;
          end
        end
      end else if (rx_wait == 0) begin
        m_tready <= 1'b1;
      end else begin
        rx_wait--;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("http_request_line_parser_top: mismatch");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input bit fixed, input parse_res_t fres);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    fres.data = b;
    s_tvalid   <= 1'b1;
    s_tdata    <= b;
    note_fixed <= fixed;
    note_res   <= fres;
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // Stops offering and waits until every predicted word has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // Queues one request: mostly well formed, some with a corrupted byte, some pure noise.
  task automatic send_request();
    logic [7:0] pkt [$];
    int kind;
    int n;
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      n = $urandom_range(1, 30);
      repeat (n) pkt.push_back(($urandom_range(0, 5) == 0) ? CH_LF : 8'($urandom_range(0, 255)));
      pkt.push_back(CH_LF);
      pkt.push_back(CH_LF);
    end else begin
      repeat ($urandom_range(1, 8)) pkt.push_back(pick(tok_chars));
      repeat ($urandom_range(1, 3)) pkt.push_back(CH_SP);
      repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom_range(33, 255)));
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 2)) pkt.push_back(CH_SP);
        repeat ($urandom_range(0, 9)) pkt.push_back(pick(ver_chars));
      end
      pkt.push_back(CH_CR);
      pkt.push_back(CH_LF);
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(1, 10)) begin
          n = $urandom_range(0, 255);
          pkt.push_back((8'(n) == CH_LF) ? 8'h61 : 8'(n));
        end
        if ($urandom_range(0, 1) != 0) pkt.push_back(CH_CR);
        pkt.push_back(CH_LF);
      end
      if ($urandom_range(0, 2) != 0) pkt.push_back(CH_CR);
      pkt.push_back(CH_LF);
      if (kind < 6) pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom_range(0, 255));
    end
    foreach (pkt[i]) send_word(pkt[i], 1'b0, '0);
    requests++;
  endtask

  initial begin : main
    parse_res_t fres;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    note_fixed = 1'b0;
    note_res   = '0;
    burst      = 1'b0;
    hold_left  = 0;
    rx_wait    = 0;
    clear_parse_state();
    ver_chars = {tok_chars, "/"};
    foreach (tok_chars[i]) tok_map[tok_chars[i]] = 1'b1;
    foreach (ver_chars[i]) ver_map[ver_chars[i]] = 1'b1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      fres      = '0;
      fres.tag  = dir_rows[i].tag;
      fres.hdr_end = dir_rows[i].hend;
      fres.ok   = dir_rows[i].ok;
      fres.mlen = dir_rows[i].m;
      fres.tlen = dir_rows[i].t;
      fres.vlen = dir_rows[i].v;
      send_word(dir_rows[i].b, dir_rows[i].fixed, fres);
    end
    drain();

    // Back-to-back offers while the output holds off, so the input side stalls.
    burst     = 1'b1;
    hold_left = HOLD_LEN;
    repeat (5) send_request();
    burst = 1'b0;
    drain();

    while (words_in < RAND_WORDS) begin
      burst = ($urandom_range(0, 4) == 0);
      send_request();
    end
    burst = 1'b0;

    drain();
    repeat (8) @(posedge clk);

    $display("Run covered %0d requests, %0d bytes, %0d words checked.",
             requests + 3, words_in, words_checked);
    $display("Header ends seen: %0d, well formed: %0d, failures: %0d.",
             hdr_ends, hdr_oks, errors + expected_q.size());
    if (errors == 0 && expected_q.size() == 0) begin
      $display("http_request_line_parser_top: match");
    end else begin
      $display("http_request_line_parser_top: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/hrlp_pkg.sv
rtl/core/hrlp_step.sv
rtl/core/http_request_line_parser_top.sv
verif/tb_top.sv
